/* rtl/core/bffa_pkg.sv */
// Package for the bump allocator: beat types, status codes and constants.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none
package bffa_pkg;
    localparam logic       OP_ALLOC     = 1'b0;
    localparam logic       OP_FREE      = 1'b1;
    localparam logic [2:0] ST_REUSED    = 3'd0;
    localparam logic [2:0] ST_BUMPED    = 3'd1;
    localparam logic [2:0] ST_NO_SPACE  = 3'd2;
    localparam logic [2:0] ST_FREED     = 3'd3;
    localparam logic [2:0] ST_UNKNOWN   = 3'd4;
    localparam logic [2:0] ST_FREE_FULL = 3'd5;
    localparam logic [2:0] ST_LIVE_FULL = 3'd6;
    localparam logic       CFG_BASE     = 1'b0;
    localparam logic       CFG_BYTES    = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] request_bytes;
        logic [31:0] block_address;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] result_address;
        logic [31:0] result_bytes;
        logic [2:0]  status;
    } t_out_beat;

    // Entry handed along the cell rows.
    typedef struct packed {
        logic        valid;
        logic [31:0] addr;
        logic [31:0] bytes;
    } t_entry;
endpackage
`default_nettype wire

/* rtl/core/bump_first_fit_allocator.sv */
// Top level of the bump allocator with a first-fit free list.
// Depends on bffa_pkg, bffa_free_cell and bffa_live_cell.
//
// Usage: requests enter on i_in_valid/o_in_stall as t_in_beat beats, results
// leave on o_out_valid/i_out_stall as t_out_beat beats, exactly one result
// per request, in order. Registers are written through i_cfg_valid/o_cfg_ready
// with index 0 for region_base and 1 for region_bytes; the user must write them
// only while the block is idle, as the block itself does not enforce this.
// Each request is first latched into the request register; from there it is
// compared in every cell of the free row and the live row at once, the first
// match is picked by priority, and the cells and the output register are updated.
// A new request is taken while the result waits, but not while one is computing.
// When the receiver stalls, the result holds in the output register and one
// further request may finish computing only once that register is free.
// Synchronous reset empties both rows, clears the bump pointer and restores
// region_base to 0 and region_bytes to 1 MiB; no clearing pass is needed.
`default_nettype none
module bump_first_fit_allocator #(
    parameter int FREE_DEPTH   = 16,
    parameter int LIVE_DEPTH   = 64,
    parameter int HEADER_BYTES = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire bffa_pkg::t_in_beat i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output bffa_pkg::t_out_beat     o_out_data,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic               i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);
    import bffa_pkg::*;
    localparam int FW = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
    localparam int LW = (LIVE_DEPTH > 1) ? $clog2(LIVE_DEPTH) : 1;
    localparam logic [33:0] HDR = 34'(HEADER_BYTES);

    logic [31:0] r_base, r_rbytes, r_bump;
    logic        r_busy;
    t_in_beat    r_req;
    t_out_beat   r_out;
    logic        r_ovalid;
    logic [FW:0] r_fcount;

    t_entry                  free_e [FREE_DEPTH];
    logic [FREE_DEPTH-1:0]   free_fit;
    logic [FREE_DEPTH-1:0]   free_shift, free_load;
    t_entry                  live_e [LIVE_DEPTH];
    logic [LIVE_DEPTH-1:0]   live_hit, live_set, live_clr;

    // Priority picks over the two rows.
    logic          f_any, l_any, e_any;
    logic [FW-1:0] f_idx;
    logic [LW-1:0] l_idx, e_idx;
    always_comb begin
        f_any = 1'b0; f_idx = '0;
        for (int i = FREE_DEPTH - 1; i >= 0; i--) begin
            if (free_fit[i]) begin
                f_any = 1'b1; f_idx = FW'(i);
            end
        end
        l_any = 1'b0; l_idx = '0; e_any = 1'b0; e_idx = '0;
        for (int j = LIVE_DEPTH - 1; j >= 0; j--) begin
            if (live_hit[j]) begin
                l_any = 1'b1; l_idx = LW'(j);
            end
            if (!live_e[j].valid) begin
                e_any = 1'b1; e_idx = LW'(j);
            end
        end
    end

    // Decision for the latched request.
    logic        do_it, act_reuse, act_bump, act_free;
    logic [33:0] end_sum;
    t_out_beat   res;
    t_entry      new_live;
    always_comb begin
        end_sum   = {2'b0, r_bump} + HDR + {2'b0, r_req.request_bytes};
        do_it     = r_busy && !(r_ovalid && i_out_stall);
        act_reuse = 1'b0; act_bump = 1'b0; act_free = 1'b0;
        res       = '0;
        new_live  = '0;
        if (r_req.opcode == OP_ALLOC) begin
            if (f_any) begin
                if (e_any) begin
                    act_reuse = 1'b1;
                    res = '{free_e[f_idx].addr, free_e[f_idx].bytes, ST_REUSED};
                end else begin
                    res.status = ST_LIVE_FULL;
                end
            end else if (end_sum > {2'b0, r_rbytes}) begin
                res.status = ST_NO_SPACE;
            end else if (!e_any) begin
                res.status = ST_LIVE_FULL;
            end else begin
                act_bump = 1'b1;
                res = '{r_base + r_bump + HDR[31:0], r_req.request_bytes, ST_BUMPED};
            end
            new_live = '{1'b1, res.result_address, res.result_bytes};
        end else begin
            res.result_address = r_req.block_address;
            if (!l_any) begin
                res.status = ST_UNKNOWN;
            end else if (r_fcount >= (FW+1)'(FREE_DEPTH)) begin
                res.status = ST_FREE_FULL;
            end else begin
                act_free = 1'b1;
                res.result_bytes = live_e[l_idx].bytes;
                res.status = ST_FREED;
            end
        end
    end

    // Cell controls.
    always_comb begin
        for (int i = 0; i < FREE_DEPTH; i++) begin
            free_shift[i] = do_it && act_reuse && (FW'(i) >= f_idx);
            free_load[i]  = do_it && act_free && (r_fcount == (FW+1)'(i));
        end
        for (int j = 0; j < LIVE_DEPTH; j++) begin
            live_set[j] = do_it && (act_reuse || act_bump) && (e_idx == LW'(j));
            live_clr[j] = do_it && act_free && (l_idx == LW'(j));
        end
    end

    t_entry free_in;
    assign free_in = '{1'b1, r_req.block_address, live_e[l_idx].bytes};

    genvar g;
    generate
        for (g = 0; g < FREE_DEPTH; g++) begin : g_free
            t_entry nxt;
            if (g == FREE_DEPTH - 1) begin : g_top
                assign nxt = '0;
            end else begin : g_mid
                assign nxt = free_e[g+1];
            end
            bffa_free_cell u_cell (
                .i_clk, .i_rst_n,
                .i_req       (r_req.request_bytes),
                .i_shift     (free_shift[g]),
                .i_next      (nxt),
                .i_load      (free_load[g]),
                .i_load_data (free_in),
                .o_entry     (free_e[g]),
                .o_fit       (free_fit[g])
            );
        end
        for (g = 0; g < LIVE_DEPTH; g++) begin : g_live
            bffa_live_cell u_cell (
                .i_clk, .i_rst_n,
                .i_addr  (r_req.block_address),
                .i_set   (live_set[g]),
                .i_clr   (live_clr[g]),
                .i_data  (new_live),
                .o_entry (live_e[g]),
                .o_hit   (live_hit[g])
            );
        end
    endgenerate

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // Request latch, output register and scalar state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_bump   <= '0;
            r_fcount <= '0;
            r_base   <= '0;
            r_rbytes <= 32'd1048576;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_BASE) r_base <= i_cfg_data;
                else                         r_rbytes <= i_cfg_data;
            end
            if (i_in_valid && !r_busy) begin
                r_busy <= 1'b1;
                r_req  <= i_in_data;
            end
            // A finished request refills the output register; otherwise a
            // drained beat empties it.
            if (do_it) begin
                r_busy   <= 1'b0;
                r_ovalid <= 1'b1;
                r_out    <= res;
                if (act_bump)  r_bump <= end_sum[31:0];
                if (act_reuse) r_fcount <= r_fcount - 1'b1;
                if (act_free)  r_fcount <= r_fcount + 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/core/bffa_free_cell.sv */
// One cell of the ordered free list; compares, and shifts toward its neighbor.
// Depends on bffa_pkg.
`default_nettype none
module bffa_free_cell (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [31:0]      i_req,
    input  wire logic             i_shift,
    input  wire bffa_pkg::t_entry i_next,
    input  wire logic             i_load,
    input  wire bffa_pkg::t_entry i_load_data,
    output bffa_pkg::t_entry      o_entry,
    output logic                  o_fit
);
    import bffa_pkg::*;
    t_entry r_e;

    // Occupied cells report whether they hold a big enough block.
    assign o_entry = r_e;
    assign o_fit   = r_e.valid && (r_e.bytes >= i_req);

    // A shift pulls the upper neighbor down; a load appends at the tail.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e.valid <= 1'b0;
        end else if (i_shift) begin
            r_e <= i_next;
        end else if (i_load) begin
            r_e <= i_load_data;
        end
    end
endmodule
`default_nettype wire

/* rtl/core/bffa_live_cell.sv */
// One cell of the live table: holds an address and its size, matches frees.
// Depends on bffa_pkg.
`default_nettype none
module bffa_live_cell (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [31:0]      i_addr,
    input  wire logic             i_set,
    input  wire logic             i_clr,
    input  wire bffa_pkg::t_entry i_data,
    output bffa_pkg::t_entry      o_entry,
    output logic                  o_hit
);
    import bffa_pkg::*;
    t_entry r_e;

    assign o_entry = r_e;
    assign o_hit   = r_e.valid && (r_e.addr == i_addr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e.valid <= 1'b0;
        end else if (i_set) begin
            r_e <= i_data;
        end else if (i_clr) begin
            r_e.valid <= 1'b0;
        end
    end
endmodule
`default_nettype wire

/* sim/bump_first_fit_allocator_test.sv */
// Self-checking testbench for bump_first_fit_allocator: a directed table, an overflow
// run, then random allocate/free traffic checked against a behavioral allocator model.
// Depends on bffa_pkg and the bump_first_fit_allocator RTL.
`timescale 1ns / 100ps
module bump_first_fit_allocator_test;
    import bffa_pkg::*;

    localparam int FREE_DEPTH   = 16;
    localparam int LIVE_DEPTH   = 64;
    localparam int HEADER_BYTES = 4;
    localparam int WATCHDOG     = 20000;
    localparam int RANDOM_ITEMS = 1150;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_beat    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_beat   o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [31:0] i_cfg_data;

    bump_first_fit_allocator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Model of the allocator state.
    logic [31:0] m_base;
    logic [31:0] m_size;
    logic [31:0] m_bump;
    logic [31:0] m_free_addr [FREE_DEPTH];
    logic [31:0] m_free_len  [FREE_DEPTH];
    int          m_free_count;
    logic [31:0] m_live_addr [LIVE_DEPTH];
    logic [31:0] m_live_len  [LIVE_DEPTH];
    logic        m_live_ok   [LIVE_DEPTH];

    t_out_beat   pending_results [$];
    logic [31:0] handed_out [$];
    int          error_count;
    int          idle_cycles = 0;
    logic        rx_hold;

    // Directed table: a check flag marks rows with a typed-in result.
    typedef struct {
        t_in_beat  req;
        logic      fixed;
        t_out_beat res;
    } t_row;

    task automatic model_reset();
        m_base = '0;
        m_size = 32'd1048576;
        m_bump = '0;
        m_free_count = 0;
        for (int i = 0; i < LIVE_DEPTH; i++) m_live_ok[i] = 1'b0;
    endtask

    function automatic t_out_beat predict_allocation(t_in_beat req);
        t_out_beat r;
        int        slot;
        logic [63:0] reach;
        slot = -1;
        r = '0;
        for (int i = LIVE_DEPTH - 1; i >= 0; i--) if (!m_live_ok[i]) slot = i;
        if (req.opcode == OP_ALLOC) begin
            for (int i = 0; i < m_free_count; i++) begin
                if (m_free_len[i] >= req.request_bytes) begin
                    if (slot < 0) begin
                        r.status = ST_LIVE_FULL;
                        return r;
                    end
                    r = '{m_free_addr[i], m_free_len[i], ST_REUSED};
                    for (int j = i; j < m_free_count - 1; j++) begin
                        m_free_addr[j] = m_free_addr[j + 1];
                        m_free_len[j]  = m_free_len[j + 1];
                    end
                    m_free_count--;
                    m_live_addr[slot] = r.result_address;
                    m_live_len[slot]  = r.result_bytes;
                    m_live_ok[slot]   = 1'b1;
                    return r;
                end
            end
            reach = 64'(m_bump) + HEADER_BYTES + 64'(req.request_bytes);
            if (reach > 64'(m_size)) begin
                r.status = ST_NO_SPACE;
            end else if (slot < 0) begin
                r.status = ST_LIVE_FULL;
            end else begin
                r = '{m_base + m_bump + HEADER_BYTES, req.request_bytes, ST_BUMPED};
                m_bump = reach[31:0];
                m_live_addr[slot] = r.result_address;
                m_live_len[slot]  = r.result_bytes;
                m_live_ok[slot]   = 1'b1;
            end
            return r;
        end
        r.result_address = req.block_address;
        r.status = ST_UNKNOWN;
        for (int i = 0; i < LIVE_DEPTH; i++) begin
            if (m_live_ok[i] && m_live_addr[i] == req.block_address) begin
                if (m_free_count >= FREE_DEPTH) begin
                    r.status = ST_FREE_FULL;
                end else begin
                    m_free_addr[m_free_count] = req.block_address;
                    m_free_len[m_free_count]  = m_live_len[i];
                    m_free_count++;
                    m_live_ok[i] = 1'b0;
                    r.result_bytes = m_live_len[i];
                    r.status = ST_FREED;
                end
                return r;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result checking and watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("bump_first_fit_allocator_test failed");
                $finish;
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected beat", o_out_data.result_address, '0);
                end else begin
                    t_out_beat want;
                    want = pending_results.pop_front();
                    if (o_out_data.result_address !== want.result_address)
                        report_mismatch("result_address", o_out_data.result_address,
                                        want.result_address);
                    if (o_out_data.result_bytes !== want.result_bytes)
                        report_mismatch("result_bytes", o_out_data.result_bytes,
                                        want.result_bytes);
                    if (o_out_data.status !== want.status)
                        report_mismatch("status", 32'(o_out_data.status),
                                        32'(want.status));
                end
            end
        end
    end

    // Receiver: random stall per beat, or a long hold when asked.
    initial begin
        int gap;
        i_out_stall = 1'b1;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (rx_hold) begin
                i_out_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            gap = $urandom_range(0, 3);
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk iff o_out_valid);
        end
    end

    // Valid stays up after the accepting edge until the next call drives a
    // new beat or an idle gap in the same time step.
    task automatic send_request(input t_in_beat req, input int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_data  <= req;
        i_in_valid <= 1'b1;
        pending_results.insert(pending_results.size(), predict_allocation(req));
        @(posedge i_clk iff !o_in_stall);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [31:0] value);
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk iff o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_BASE) m_base = value;
        else m_size = value;
    endtask

    // Random request: allocations and frees, frees mostly of handed-out addresses.
    function automatic t_in_beat random_request(input int mode);
        t_in_beat r;
        r.opcode = $urandom_range(0, 99) < 45 ? OP_FREE : OP_ALLOC;
        r.block_address = $urandom;
        case ($urandom_range(0, 9))
            0: r.request_bytes = $urandom;
            1: r.request_bytes = 32'hFFFF_FFFF - $urandom_range(0, 8);
            default: r.request_bytes = $urandom_range(0, mode == 0 ? 64 : 4096);
        endcase
        if (r.opcode == OP_FREE && handed_out.size() != 0 && $urandom_range(0, 9) < 8)
            r.block_address = handed_out[$urandom_range(0, handed_out.size() - 1)];
        return r;
    endfunction

    initial begin
        t_row      rows [$];
        t_in_beat  req;
        t_out_beat res;
        error_count = 0;
        rx_hold     = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_BASE;
        i_cfg_data  = '0;
        model_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows after reset: first bump, unknown free, no space, free, double free, reuse.
        rows.insert(rows.size(),
                    '{'{OP_ALLOC, 32'd16, 32'd0}, 1'b1, '{32'd4, 32'd16, ST_BUMPED}});
        rows.insert(rows.size(),
                    '{'{OP_FREE, 32'd0, 32'd99}, 1'b1, '{32'd99, 32'd0, ST_UNKNOWN}});
        rows.insert(rows.size(), '{'{OP_ALLOC, 32'hFFFF_FFFF, 32'd0}, 1'b1,
                                   '{32'd0, 32'd0, ST_NO_SPACE}});
        rows.insert(rows.size(),
                    '{'{OP_FREE, 32'd0, 32'd4}, 1'b1, '{32'd4, 32'd16, ST_FREED}});
        rows.insert(rows.size(),
                    '{'{OP_FREE, 32'd0, 32'd4}, 1'b1, '{32'd4, 32'd0, ST_UNKNOWN}});
        rows.insert(rows.size(), '{'{OP_ALLOC, 32'd8, 32'hFFFF_FFFF}, 1'b1,
                                   '{32'd4, 32'd16, ST_REUSED}});
        rows.insert(rows.size(), '{'{OP_ALLOC, 32'd0, 32'd0}, 1'b0, '0});
        rows.insert(rows.size(), '{'{OP_ALLOC, 32'd1048576 - 32'd28, 32'd0}, 1'b0, '0});
        rows.insert(rows.size(), '{'{OP_ALLOC, 32'd0, 32'd0}, 1'b0, '0});
        foreach (rows[i]) begin
            res = predict_allocation(rows[i].req);
            if (rows[i].fixed && res != rows[i].res)
                report_mismatch("table row", 32'(i), 32'(res.status));
            pending_results.insert(pending_results.size(),
                                   rows[i].fixed ? rows[i].res : res);
            i_in_data  <= rows[i].req;
            i_in_valid <= 1'b1;
            @(posedge i_clk iff !o_in_stall);
        end
        wait_drained();

        // Fill the live table, then overflow it and the free list.
        write_register(CFG_BYTES, 32'hFFFF_FFFF);
        write_register(CFG_BASE, 32'hFFFF_FF00);
        for (int i = 0; i < LIVE_DEPTH + 2; i++) begin
            req = '{OP_ALLOC, 32'($urandom_range(0, 16)), $urandom};
            send_request(req, 0);
            handed_out.insert(handed_out.size(), pending_results[$].result_address);
        end
        for (int i = 0; i < FREE_DEPTH + 3; i++)
            send_request('{OP_FREE, $urandom, handed_out[i]}, 0);
        send_request('{OP_ALLOC, 32'd0, 32'd0}, 0);
        wait_drained();

        // Random phases across several region settings.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    write_register(CFG_BASE, 32'd0);
                    write_register(CFG_BYTES, 32'd4);
                end
                1: begin
                    write_register(CFG_BASE, $urandom);
                    write_register(CFG_BYTES, 32'($urandom_range(4, 200000)));
                end
                2: write_register(CFG_BYTES, 32'hFFFF_FFFF);
                3: write_register(CFG_BYTES, 32'($urandom_range(4, 100)));
                default: begin
                    write_register(CFG_BASE, 32'hFFFF_FFFC);
                    write_register(CFG_BYTES, 32'hFFFF_FFFF);
                end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 5; n++) begin
                if (phase == 2 && n == 20) rx_hold = 1'b1;
                req = random_request(phase & 1);
                send_request(req, n < 30 ? 0 : $urandom_range(0, 3));
                res = pending_results[$];
                if (res.status == ST_BUMPED || res.status == ST_REUSED)
                    handed_out.insert(handed_out.size(), res.result_address);
                if (handed_out.size() > 96) void'(handed_out.pop_front());
            end
            wait_drained();
        end

        if (error_count == 0)
            $display("bump_first_fit_allocator_test passed");
        else
            $display("bump_first_fit_allocator_test failed");
        $finish;
    end
endmodule
